[hw/rtl/swe_pkg.sv]
// Shared types and constants for the sliding-window entropy block.
`default_nettype none
package swe_pkg;

   localparam int SYM_W     = 8;
   localparam int CFG_W     = 11;
   localparam int OUT_W     = 16;
   localparam int NOUT_W    = 11;
   localparam int BINS      = 256;
   localparam int LOG_FRAC  = 28;
   localparam int MANT_ONE  = 30;
   localparam int ROUND_SH  = 15;
   localparam int SCALE_SH  = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
   localparam logic [OUT_W-1:0] H_MAX     = 16'd32768;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH_OLD,
      ST_GET_OLD,
      ST_READ_NEW,
      ST_GET_NEW,
      ST_TERM_LOG,
      ST_TERM_WAIT,
      ST_TERM_ACC,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_OLD_SUB,
      STEP_OLD_ADD,
      STEP_NEW_SUB,
      STEP_NEW_ADD,
      STEP_TOTAL
   } step_type;

endpackage
`default_nettype wire

[hw/rtl/swe_log.sv]
// Iterative log2 unit: integer part by leading one, fraction by repeated squaring.
`default_nettype none
module swe_log #(
   parameter int XW = 11,
   parameter int EW = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [XW-1:0]                 x,
   output logic                               done,
   output logic [EW+swe_pkg::LOG_FRAC-1:0]    result
);

   localparam int MW = swe_pkg::MANT_ONE + 1;
   localparam int KW = $clog2(swe_pkg::LOG_FRAC + 1);

   logic [MW-1:0]                 y_ff;
   logic [EW-1:0]                 e_ff;
   logic [swe_pkg::LOG_FRAC-1:0]  frac_ff;
   logic [KW-1:0]                 k_ff;
   logic                          busy_ff;
   logic                          done_ff;

   logic [EW-1:0]                 e_lead;
   logic [XW+swe_pkg::MANT_ONE-1:0] x_wide;
   logic [2*MW-1:0]               sq;
   logic [MW:0]                   y_next;

   // find the leading one of the operand
   always_comb begin
      e_lead = '0;
      for (int i = 0; i < XW; i++) begin
         if (x[i]) e_lead = EW'(i);
      end
      x_wide = {x, {swe_pkg::MANT_ONE{1'b0}}} >> e_lead;
   end

   // square the mantissa and drop it back to Q1.30
   assign sq     = {{MW{1'b0}}, y_ff} * {{MW{1'b0}}, y_ff};
   assign y_next = sq[2*MW-1:swe_pkg::MANT_ONE];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            k_ff <= k_ff + KW'(1);
            if (k_ff == KW'(swe_pkg::LOG_FRAC - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // mantissa, exponent and fraction bits
   always_ff @(posedge clock) begin
      if (start) begin
         y_ff    <= x_wide[MW-1:0];
         e_ff    <= e_lead;
         frac_ff <= '0;
      end else if (busy_ff) begin
         if (y_next[MW]) begin
            y_ff    <= y_next[MW:1];
            frac_ff <= {frac_ff[swe_pkg::LOG_FRAC-2:0], 1'b1};
         end else begin
            y_ff    <= y_next[MW-1:0];
            frac_ff <= {frac_ff[swe_pkg::LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};

endmodule
`default_nettype wire

[hw/rtl/swe_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swe_div #(
   parameter int DW = 32,
   parameter int VW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);

   localparam int KW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [VW:0]   rem_ff;
   logic [VW-1:0] dv_ff;
   logic [KW-1:0] k_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   r2;
   logic          fits;

   // shift in the next dividend bit and try the subtraction
   assign r2   = {rem_ff[VW-1:0], q_ff[DW-1]};
   assign fits = r2 >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            k_ff <= k_ff + KW'(1);
            if (k_ff == KW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dv_ff  <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DW-2:0], fits};
         rem_ff <= fits ? r2 - {1'b0, dv_ff} : r2;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

[hw/rtl/sliding_window_entropy.sv]
// Sliding-window Shannon entropy of a byte stream, top level.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_symbol
//   rsp     | out       | rsp_valid/rsp_stall | rsp_entropy_bits, rsp_symbols_in_window
//   csr     | in        | csr_valid/csr_ready | csr_window_size
//
// One item at a time; each item runs up to five terms through the iterative log unit
// (a term with a zero count skips the log) and then one division in the divider.
// After reset and after every csr write the histogram memory is cleared, all 256 bins,
// one bin a cycle, while req_stall stays high; req_stall is also high with csr_valid.
// A finished result sits in the output register; a new item is taken while it waits.
`default_nettype none
module sliding_window_entropy #(
   parameter int MAX_WINDOW = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [swe_pkg::SYM_W-1:0]     req_symbol,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [swe_pkg::OUT_W-1:0]          rsp_entropy_bits,
   output logic [swe_pkg::NOUT_W-1:0]         rsp_symbols_in_window,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [swe_pkg::CFG_W-1:0]     csr_window_size
);

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int XW = (CW > swe_pkg::CFG_W) ? CW : swe_pkg::CFG_W;
   localparam int EW = $clog2(CW);
   localparam int LW = EW + swe_pkg::LOG_FRAC;
   localparam int PW = CW + LW;
   localparam int SW = PW + swe_pkg::SYM_W;
   localparam int DW = SW + 1 - swe_pkg::SCALE_SH;
   localparam int BW = $clog2(swe_pkg::BINS);

   swe_pkg::state_type state_ff, state_in;
   swe_pkg::step_type  step_ff;

   logic [swe_pkg::CFG_W-1:0] window_ff;
   logic [AW-1:0]             wp_ff;
   logic [CW-1:0]             seen_ff;
   logic [CW-1:0]             n_ff;
   logic                      full_ff;
   logic [swe_pkg::SYM_W-1:0] sym_ff;
   logic [swe_pkg::SYM_W-1:0] old_ff;
   logic [CW-1:0]             cnt_ff;
   logic [CW-1:0]             x_ff;
   logic [PW-1:0]             prod_ff;
   logic [SW-1:0]             sum_ff;
   logic [BW-1:0]             clr_ff;
   logic [DW-1:0]             quot_ff;
   logic                      rsp_valid_ff;
   logic [swe_pkg::OUT_W-1:0] rsp_h_ff;
   logic [CW-1:0]             rsp_n_ff;

   logic [XW-1:0]             raw_x;
   logic [CW-1:0]             w_eff;
   logic [AW-1:0]             wp_use;
   logic                      full_now;
   logic                      req_acc;
   logic                      csr_acc;
   logic                      out_free;

   // memories
   logic [swe_pkg::SYM_W-1:0] wst_mem [MAX_WINDOW];
   logic [swe_pkg::SYM_W-1:0] wst_rd_ff;
   logic [CW-1:0]             hist_mem [swe_pkg::BINS];
   logic [CW-1:0]             hist_rd_ff;
   logic [BW-1:0]             hist_ra;
   logic [BW-1:0]             hist_wa;
   logic [CW-1:0]             hist_wd;
   logic                      hist_we;

   // units
   logic                      log_start;
   logic                      log_done;
   logic [LW-1:0]             log_res;
   logic                      div_start;
   logic                      div_done;
   logic [DW-1:0]             div_q;
   logic [SW-1:0]             t_val;
   logic [SW:0]               num;

   // clamp the window size to 1..MAX_WINDOW
   always_comb begin
      raw_x = XW'(window_ff);
      if (raw_x == '0) begin
         w_eff = CW'(1);
      end else if (raw_x > XW'(MAX_WINDOW)) begin
         w_eff = CW'(MAX_WINDOW);
      end else begin
         w_eff = raw_x[CW-1:0];
      end
   end

   assign wp_use   = (CW'(wp_ff) >= w_eff) ? '0 : wp_ff;
   assign full_now = seen_ff >= w_eff;
   assign req_acc  = req_valid && !req_stall;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // hold off items while a csr write is offered so none is dropped
   assign req_stall = (state_ff != swe_pkg::ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == swe_pkg::ST_IDLE);

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      log_start = 1'b0;
      div_start = 1'b0;
      hist_we   = 1'b0;
      hist_wa   = clr_ff;
      hist_wd   = '0;
      hist_ra   = sym_ff;
      unique case (state_ff)
         swe_pkg::ST_CLEAR: begin
            hist_we = 1'b1;
            if (clr_ff == BW'(swe_pkg::BINS - 1)) state_in = swe_pkg::ST_IDLE;
         end
         swe_pkg::ST_IDLE: begin
            if (csr_acc) state_in = swe_pkg::ST_CLEAR;
            else if (req_acc) state_in = swe_pkg::ST_FETCH_OLD;
         end
         swe_pkg::ST_FETCH_OLD: begin
            hist_ra  = wst_rd_ff;
            state_in = full_ff ? swe_pkg::ST_GET_OLD : swe_pkg::ST_READ_NEW;
         end
         swe_pkg::ST_GET_OLD: begin
            state_in = (hist_rd_ff == '0) ? swe_pkg::ST_READ_NEW : swe_pkg::ST_TERM_LOG;
         end
         swe_pkg::ST_READ_NEW: begin
            hist_ra  = sym_ff;
            state_in = swe_pkg::ST_GET_NEW;
         end
         swe_pkg::ST_GET_NEW: begin
            state_in = swe_pkg::ST_TERM_LOG;
         end
         swe_pkg::ST_TERM_LOG: begin
            if (x_ff == '0) begin
               state_in = swe_pkg::ST_TERM_ACC;
            end else begin
               log_start = 1'b1;
               state_in  = swe_pkg::ST_TERM_WAIT;
            end
         end
         swe_pkg::ST_TERM_WAIT: begin
            if (log_done) state_in = swe_pkg::ST_TERM_ACC;
         end
         swe_pkg::ST_TERM_ACC: begin
            unique case (step_ff)
               swe_pkg::STEP_OLD_SUB: state_in = swe_pkg::ST_TERM_LOG;
               swe_pkg::STEP_OLD_ADD: begin
                  hist_we  = 1'b1;
                  hist_wa  = old_ff;
                  hist_wd  = cnt_ff - CW'(1);
                  state_in = swe_pkg::ST_READ_NEW;
               end
               swe_pkg::STEP_NEW_SUB: state_in = swe_pkg::ST_TERM_LOG;
               swe_pkg::STEP_NEW_ADD: begin
                  hist_we  = 1'b1;
                  hist_wa  = sym_ff;
                  hist_wd  = cnt_ff + CW'(1);
                  state_in = swe_pkg::ST_TERM_LOG;
               end
               swe_pkg::STEP_TOTAL: state_in = swe_pkg::ST_DIV_START;
               default: state_in = swe_pkg::ST_IDLE;
            endcase
         end
         swe_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = swe_pkg::ST_DIV_WAIT;
         end
         swe_pkg::ST_DIV_WAIT: begin
            if (div_done) state_in = swe_pkg::ST_DONE;
         end
         swe_pkg::ST_DONE: begin
            if (out_free) state_in = swe_pkg::ST_IDLE;
         end
         default: state_in = swe_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swe_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swe_pkg::CFG_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         clr_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= swe_pkg::STEP_OLD_SUB;
      end else begin
         // raise the result as it enters the output register, drop it once taken
         if (state_ff == swe_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            swe_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               sum_ff <= '0;
            end
            swe_pkg::ST_IDLE: begin
               if (csr_acc) begin
                  window_ff <= csr_window_size;
                  wp_ff     <= '0;
                  seen_ff   <= '0;
                  clr_ff    <= '0;
               end else if (req_acc) begin
                  wp_ff   <= (CW'(wp_use) + CW'(1) >= w_eff) ? '0 : wp_use + AW'(1);
                  seen_ff <= full_now ? w_eff : seen_ff + CW'(1);
               end
            end
            swe_pkg::ST_GET_OLD: step_ff <= swe_pkg::STEP_OLD_SUB;
            swe_pkg::ST_GET_NEW: step_ff <= swe_pkg::STEP_NEW_SUB;
            swe_pkg::ST_TERM_ACC: begin
               unique case (step_ff)
                  swe_pkg::STEP_OLD_SUB: begin
                     sum_ff  <= sum_ff - SW'(prod_ff);
                     step_ff <= swe_pkg::STEP_OLD_ADD;
                  end
                  swe_pkg::STEP_OLD_ADD: sum_ff <= sum_ff + SW'(prod_ff);
                  swe_pkg::STEP_NEW_SUB: begin
                     sum_ff  <= sum_ff - SW'(prod_ff);
                     step_ff <= swe_pkg::STEP_NEW_ADD;
                  end
                  swe_pkg::STEP_NEW_ADD: begin
                     sum_ff  <= sum_ff + SW'(prod_ff);
                     step_ff <= swe_pkg::STEP_TOTAL;
                  end
                  swe_pkg::STEP_TOTAL: step_ff <= swe_pkg::STEP_TOTAL;
                  default: step_ff <= swe_pkg::STEP_OLD_SUB;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         swe_pkg::ST_IDLE: begin
            if (req_acc) begin
               sym_ff  <= req_symbol;
               full_ff <= full_now;
               n_ff    <= full_now ? w_eff : seen_ff + CW'(1);
            end
         end
         swe_pkg::ST_FETCH_OLD: old_ff <= wst_rd_ff;
         swe_pkg::ST_GET_OLD, swe_pkg::ST_GET_NEW: begin
            cnt_ff <= hist_rd_ff;
            x_ff   <= hist_rd_ff;
         end
         swe_pkg::ST_TERM_LOG: begin
            if (x_ff == '0) prod_ff <= '0;
         end
         swe_pkg::ST_TERM_WAIT: begin
            if (log_done) prod_ff <= PW'(x_ff) * PW'(log_res);
         end
         swe_pkg::ST_TERM_ACC: begin
            unique case (step_ff)
               swe_pkg::STEP_OLD_SUB: x_ff <= cnt_ff - CW'(1);
               swe_pkg::STEP_NEW_SUB: x_ff <= cnt_ff + CW'(1);
               swe_pkg::STEP_NEW_ADD: x_ff <= n_ff;
               default: x_ff <= x_ff;
            endcase
         end
         swe_pkg::ST_DIV_WAIT: begin
            if (div_done) quot_ff <= div_q;
         end
         swe_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_h_ff <= (quot_ff > DW'(swe_pkg::H_MAX)) ? swe_pkg::H_MAX
                                                          : quot_ff[swe_pkg::OUT_W-1:0];
               rsp_n_ff <= n_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // window store: read the leaving symbol and write the new one in the same cycle
   always_ff @(posedge clock) begin
      if (req_acc) begin
         wst_rd_ff       <= wst_mem[wp_use];
         wst_mem[wp_use] <= req_symbol;
      end
   end

   // histogram memory
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wa] <= hist_wd;
      hist_rd_ff <= hist_mem[hist_ra];
   end

   swe_log #(
      .XW (CW),
      .EW (EW)
   ) u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (x_ff),
      .done   (log_done),
      .result (log_res)
   );

   // clamp the total minus the sum at zero and add the rounding half
   assign t_val = (SW'(prod_ff) > sum_ff) ? SW'(prod_ff) - sum_ff : '0;
   assign num   = {1'b0, t_val} + ((SW + 1)'(n_ff) << swe_pkg::ROUND_SH);

   swe_div #(
      .DW (DW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num[SW:swe_pkg::SCALE_SH]),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entropy_bits      = rsp_h_ff;
   assign rsp_symbols_in_window = swe_pkg::NOUT_W'(rsp_n_ff);

endmodule
`default_nettype wire
